>>> rtl/sbus_frame_decoder_macros.svh
// Assertion macros shared by the SBUS frame decoder RTL.
// Expects clk and rst in the scope of the including module.
`ifndef SBUS_FRAME_DECODER_MACROS_SVH
`define SBUS_FRAME_DECODER_MACROS_SVH

// same-cycle implication
`define SBUSD_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sbusd assertion failed");

// next-cycle implication
`define SBUSD_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sbusd assertion failed");

`endif

>>> rtl/sbusd_pkg.sv
// Package for the SBUS frame decoder: sizes, byte and status codes, and the
// structs passed between the collector, the unpacker and the top level.
`default_nettype none

package sbusd_pkg;

  localparam int FRAME_BYTES  = 25;
  localparam int NUM_CHANNELS = 16;
  localparam int CHANNEL_BITS = 11;

  localparam int FILL_W    = $clog2(FRAME_BYTES);
  localparam int SREG_W    = (FRAME_BYTES - 1) * 8;
  localparam int BIT_CNT_W = (CHANNEL_BITS > 1) ? $clog2(CHANNEL_BITS) : 1;

  localparam logic [7:0] START_BYTE = 8'h0F;
  localparam logic [7:0] END_BYTE   = 8'h00;

  localparam logic [1:0] STAT_CHAN      = 2'd0;
  localparam logic [1:0] STAT_BAD_START = 2'd1;
  localparam logic [1:0] STAT_BAD_END   = 2'd2;

  localparam logic [3:0] LAST_CH = 4'(NUM_CHANNELS - 1);

  typedef struct packed {
    logic       shift_in;
    logic       take_flags;
    logic       frame_done;
    logic       err_valid;
    logic [1:0] err_status;
  } col_t;

  typedef struct packed {
    logic                    emit;
    logic                    last;
    logic [3:0]              ch;
    logic [CHANNEL_BITS-1:0] value;
    logic [3:0]              flags;
  } emit_t;

endpackage

`default_nettype wire

>>> rtl/sbusd_collect.sv
// Byte collector: counts frame bytes, checks start and end bytes and
// flags errors. Depends on sbusd_pkg.
`default_nettype none

module sbusd_collect (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         accept,
  input  wire logic [7:0]   rx_byte,
  output sbusd_pkg::col_t   col
);
  import sbusd_pkg::*;

  localparam logic [FILL_W-1:0] LAST_FILL  = FILL_W'(FRAME_BYTES - 1);
  localparam logic [FILL_W-1:0] FLAGS_FILL = FILL_W'(FRAME_BYTES - 2);

  logic [FILL_W-1:0] fill;
  logic [FILL_W-1:0] fill_next;

  always_comb begin
    col       = '0;
    fill_next = fill;
    if (accept) begin
      if (fill == '0 && rx_byte != START_BYTE) begin
        col.err_valid  = 1'b1;
        col.err_status = STAT_BAD_START;
      end else if (fill == LAST_FILL && rx_byte != END_BYTE) begin
        col.err_valid  = 1'b1;
        col.err_status = STAT_BAD_END;
        fill_next      = '0;
      end else begin
        col.shift_in   = (fill != '0);
        col.take_flags = (fill == FLAGS_FILL);
        if (fill == LAST_FILL) begin
          col.frame_done = 1'b1;
          fill_next      = '0;
        end else begin
          fill_next = fill + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else begin
      fill <= fill_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/sbusd_unpack.sv
// Bit-serial unpacker: frame bytes shift into a wide shift register, then
// channel values shift out one bit per cycle, LSB first. Depends on sbusd_pkg.
`default_nettype none

module sbusd_unpack (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic [7:0]   rx_byte,
  input  sbusd_pkg::col_t   col,
  output logic              running,
  output sbusd_pkg::emit_t  em
);
  import sbusd_pkg::*;

  localparam logic [BIT_CNT_W-1:0] LAST_BIT = BIT_CNT_W'(CHANNEL_BITS - 1);

  logic [SREG_W-1:0]       sreg;
  logic [CHANNEL_BITS-1:0] val;
  logic [CHANNEL_BITS:0]   val_wide;
  logic [CHANNEL_BITS-1:0] val_next;
  logic [3:0]              flags;
  logic [BIT_CNT_W-1:0]    bit_cnt;
  logic [3:0]              ch;

  assign val_wide = {sreg[0], val};
  assign val_next = val_wide[CHANNEL_BITS:1];

  always_comb begin
    em.emit  = running && (bit_cnt == LAST_BIT);
    em.last  = (ch == LAST_CH);
    em.ch    = ch;
    em.value = val_next;
    em.flags = flags;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      bit_cnt <= '0;
      ch      <= '0;
    end else if (col.frame_done) begin
      running <= 1'b1;
      bit_cnt <= '0;
      ch      <= '0;
    end else if (running) begin
      if (bit_cnt == LAST_BIT) begin
        bit_cnt <= '0;
        ch      <= ch + 1'b1;
        if (ch == LAST_CH) begin
          running <= 1'b0;
        end
      end else begin
        bit_cnt <= bit_cnt + 1'b1;
      end
    end
  end

  // bits past the end of the frame shift in as zero
  always_ff @(posedge clk) begin
    if (col.shift_in) begin
      sreg <= {rx_byte, sreg[SREG_W-1:8]};
    end else if (running) begin
      sreg <= {1'b0, sreg[SREG_W-1:1]};
    end
    if (running) begin
      val <= val_next;
    end
    if (col.take_flags) begin
      flags <= rx_byte[3:0];
    end
  end

endmodule

`default_nettype wire

>>> rtl/sbus_frame_decoder.sv
// SBUS frame decoder top level: collector, bit-serial unpacker and result
// registers. Depends on sbusd_pkg, sbusd_collect, sbusd_unpack and the macros.
//
// Usage: present one received byte on rx_byte with start high; it is taken
// at a clock edge where busy is low. Bytes of a frame may come at any pace.
// The first byte must be 0x0F and the final byte 0x00; a wrong byte there
// gives one error result (status bad start / bad end, last set) on the cycle
// after it is taken, and collection restarts with busy staying low.
// Middle bytes give no result.
// When the final byte is taken, busy rises for the unpack run: each channel
// value is shifted out of the frame shift register one bit per cycle.
// Each channel result sits on the result ports for one cycle with strobe
// high; the last one carries last. The receiver cannot stall.
// Reset (rst, synchronous) empties the frame count and stops any run;
// the frame shift register keeps its contents and needs no clearing.
`default_nettype none
`include "sbus_frame_decoder_macros.svh"

module sbus_frame_decoder (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  input  wire logic [7:0]                      rx_byte,
  output logic                                 busy,
  output logic                                 strobe,
  output logic [1:0]                           status,
  output logic [3:0]                           channel_index,
  output logic [sbusd_pkg::CHANNEL_BITS-1:0]   channel_value,
  output logic                                 digital_zero,
  output logic                                 digital_one,
  output logic                                 signal_lost,
  output logic                                 failsafe,
  output logic                                 last
);
  import sbusd_pkg::*;

  logic  accept;
  logic  running;
  col_t  col;
  emit_t em;

  assign accept = start && !busy;
  assign busy   = running;

  sbusd_collect u_collect (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .rx_byte (rx_byte),
    .col     (col)
  );

  sbusd_unpack u_unpack (
    .clk     (clk),
    .rst     (rst),
    .rx_byte (rx_byte),
    .col     (col),
    .running (running),
    .em      (em)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= col.err_valid || em.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (col.err_valid) begin
      status        <= col.err_status;
      channel_index <= '0;
      channel_value <= '0;
      digital_zero  <= 1'b0;
      digital_one   <= 1'b0;
      signal_lost   <= 1'b0;
      failsafe      <= 1'b0;
      last          <= 1'b1;
    end else if (em.emit) begin
      status        <= STAT_CHAN;
      channel_index <= em.ch;
      channel_value <= em.value;
      digital_zero  <= em.flags[0];
      digital_one   <= em.flags[1];
      signal_lost   <= em.flags[2];
      failsafe      <= em.flags[3];
      last          <= em.last;
    end
  end

  `SBUSD_ASSERT_IMP(a_err_is_last, strobe && status != STAT_CHAN, last)
  `SBUSD_ASSERT_IMP(a_last_chan_idx, strobe && status == STAT_CHAN && last,
                    channel_index == LAST_CH)
  `SBUSD_ASSERT_IMP(a_run_start_quiet, $rose(busy), !strobe)
  `SBUSD_ASSERT_IMP(a_mid_run_busy, strobe && !last, busy)

endmodule

`default_nettype wire
